// File: sv/imq_pkg.sv
// Package for the indexed max priority queue: sizes, entry type, action and status codes,
// and the command and status structs between controller and datapath. No dependencies.
package imq_pkg;

  localparam int unsigned Capacity = 256;
  localparam int unsigned KeyBits  = 8;
  localparam int unsigned IdBits   = 16;
  localparam int unsigned AmtBits  = 8;
  localparam int unsigned SeqBits  = 32;
  localparam int unsigned AddrBits = $clog2(Capacity);
  localparam int unsigned CntBits  = $clog2(Capacity + 1);

  localparam logic [1:0] ActInsert = 2'd0;
  localparam logic [1:0] ActRaise  = 2'd1;
  localparam logic [1:0] ActRemove = 2'd2;
  localparam logic [1:0] ActQuery  = 2'd3;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StFull     = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;
  localparam logic [1:0] StSat      = 2'd3;

  typedef struct packed {
    logic [IdBits-1:0]  id;
    logic [KeyBits-1:0] key;
    logic [SeqBits-1:0] seq;
  } entry_t;

  // Datapath operations, one per cycle, chosen by the controller.
  typedef enum logic [3:0] {
    OpNone,
    OpLoad,      // latch input beat, set initial status
    OpInsert,    // write new entry at count, cur = count
    OpScanRd,    // read slot scan index, flag exhaustion
    OpScanChk,   // compare read id, advance scan
    OpRaiseWr,   // write raised key at cur
    OpRemMove,   // move last entry into cur slot
    OpRdCur,     // read cur
    OpRdA,       // read parent or left child
    OpRdB,       // read right child, hold left child
    OpCapture,   // hold last read as parent or right child
    OpSwapA,     // write partner entry to cur, cur = partner
    OpSwapB,     // write old cur entry to new cur
    OpRdTop      // read slot zero
  } op_e;

  typedef struct packed {
    op_e  op;
    logic down;  // sift direction for compare/swap
  } cmd_t;

  typedef struct packed {
    logic [1:0]  action;
    logic        full;
    logic        scan_done;
    logic        found;
    logic        last_slot;  // cur is the last live entry at removal
    logic        up_swap;    // parent loses to cur
    logic        dn_swap;    // a child beats cur
  } stat_t;

endpackage

// File: sv/imq_if.sv
// Valid/ready channel interface carrying one payload per beat.
// Depends on nothing; the payload type is given per instance.
interface imq_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/imq_ctrl.sv
// Controller of the indexed max priority queue: sequences load, search, sift and report.
// Depends on imq_pkg.
module imq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  imq_pkg::stat_t  stat_i,
  output imq_pkg::cmd_t   cmd_o
);

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SDecide = 4'd1;
  localparam logic [3:0] SScanRd = 4'd2;
  localparam logic [3:0] SScanCk = 4'd3;
  localparam logic [3:0] SAct    = 4'd4;
  localparam logic [3:0] SRdCur  = 4'd5;
  localparam logic [3:0] SRdA    = 4'd6;
  localparam logic [3:0] SRdB    = 4'd7;
  localparam logic [3:0] SCmp    = 4'd8;
  localparam logic [3:0] SSwapB  = 4'd9;
  localparam logic [3:0] STop    = 4'd10;
  localparam logic [3:0] STopW   = 4'd11;
  localparam logic [3:0] SOut    = 4'd12;
  localparam logic [3:0] SCap    = 4'd13;

  logic [3:0] state_q, state_d;
  logic       down_q, down_d;
  logic       up_after_q, up_after_d;

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      down_q     <= 1'b0;
      up_after_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      down_q     <= down_d;
      up_after_q <= up_after_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    down_d     = down_q;
    up_after_d = up_after_q;
    cmd_o.op   = imq_pkg::OpNone;
    cmd_o.down = down_q;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.op = imq_pkg::OpLoad;
          state_d  = SDecide;
        end
      end
      SDecide: begin
        unique case (stat_i.action)
          imq_pkg::ActInsert: begin
            if (stat_i.full) begin
              state_d = STop;
            end else begin
              cmd_o.op   = imq_pkg::OpInsert;
              down_d     = 1'b0;
              up_after_d = 1'b0;
              state_d    = SRdCur;
            end
          end
          imq_pkg::ActRaise, imq_pkg::ActRemove: state_d = SScanRd;
          default: state_d = STop;
        endcase
      end
      SScanRd: begin
        cmd_o.op = imq_pkg::OpScanRd;
        state_d  = stat_i.scan_done ? STop : SScanCk;
      end
      SScanCk: begin
        cmd_o.op = imq_pkg::OpScanChk;
        state_d  = stat_i.found ? SAct : SScanRd;
      end
      SAct: begin
        if (stat_i.action == imq_pkg::ActRaise) begin
          cmd_o.op   = imq_pkg::OpRaiseWr;
          down_d     = 1'b0;
          up_after_d = 1'b0;
          state_d    = SRdCur;
        end else begin
          cmd_o.op = imq_pkg::OpRemMove;
          if (stat_i.last_slot) begin
            state_d = STop;
          end else begin
            down_d     = 1'b1;
            up_after_d = 1'b1;
            state_d    = SRdCur;
          end
        end
      end
      SRdCur: begin
        cmd_o.op = imq_pkg::OpRdCur;
        state_d  = SRdA;
      end
      SRdA: begin
        cmd_o.op = imq_pkg::OpRdA;
        state_d  = down_q ? SRdB : SCap;
      end
      SRdB: begin
        cmd_o.op = imq_pkg::OpRdB;
        state_d  = SCap;
      end
      SCap: begin
        cmd_o.op = imq_pkg::OpCapture;
        state_d  = SCmp;
      end
      SCmp: begin
        if (down_q ? stat_i.dn_swap : stat_i.up_swap) begin
          cmd_o.op = imq_pkg::OpSwapA;
          state_d  = SSwapB;
        end else if (up_after_q) begin
          down_d     = 1'b0;
          up_after_d = 1'b0;
          state_d    = SRdCur;
        end else begin
          state_d = STop;
        end
      end
      SSwapB: begin
        cmd_o.op = imq_pkg::OpSwapB;
        state_d  = SRdCur;
      end
      STop: begin
        cmd_o.op = imq_pkg::OpRdTop;
        state_d  = STopW;
      end
      STopW: state_d = SOut;
      SOut: begin
        if (out_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

endmodule

// File: sv/imq_dp.sv
// Datapath of the indexed max priority queue: heap memory, counters, compare logic.
// Depends on imq_pkg.
module imq_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  imq_pkg::cmd_t                 cmd_i,
  input  logic [1:0]                    action_i,
  input  logic [imq_pkg::IdBits-1:0]    entry_id_i,
  input  logic [imq_pkg::AmtBits-1:0]   amount_i,
  output imq_pkg::stat_t                stat_o,
  output logic [imq_pkg::IdBits-1:0]    top_id_o,
  output logic                          is_empty_o,
  output logic [1:0]                    status_o
);

  localparam int unsigned AW = imq_pkg::AddrBits;
  localparam int unsigned CW = imq_pkg::CntBits;
  localparam int unsigned SumBits = (imq_pkg::KeyBits > imq_pkg::AmtBits ?
                                     imq_pkg::KeyBits : imq_pkg::AmtBits) + 1;

  imq_pkg::entry_t mem_q [imq_pkg::Capacity];

  logic [CW-1:0]               count_q;
  logic [imq_pkg::SeqBits-1:0] seq_q;
  logic [1:0]                  act_q, status_q;
  logic [imq_pkg::IdBits-1:0]  id_q;
  logic [imq_pkg::AmtBits-1:0] amt_q;
  logic [CW-1:0]               scan_q, cur_q;
  imq_pkg::entry_t             rd_q, cur_e_q, a_e_q, b_e_q;
  logic                        a_ok_q, b_ok_q;

  logic                        wr_en;
  logic [AW-1:0]               wr_addr, rd_addr;
  imq_pkg::entry_t             wr_data;
  logic                        rd_en;
  logic [CW-1:0]               left_idx, right_idx, parent_idx;
  logic [SumBits-1:0]          key_sum;
  logic [imq_pkg::KeyBits-1:0] key_sat;
  logic                        sat;
  logic                        a_beats, b_beats_best, a_lower_cur;
  imq_pkg::entry_t             best_e;
  logic [CW-1:0]               best_idx;

  function automatic logic lower(imq_pkg::entry_t a, imq_pkg::entry_t b);
    if (a.key != b.key) return a.key < b.key;
    return a.seq > b.seq;
  endfunction

  assign left_idx   = CW'({cur_q, 1'b1});
  assign right_idx  = left_idx + CW'(1);
  assign parent_idx = (cur_q - CW'(1)) >> 1;

  // Insert starts from the amount, raise from the stored key.
  always_comb begin
    if (act_q == imq_pkg::ActInsert) key_sum = SumBits'(amt_q);
    else key_sum = SumBits'(rd_q.key) + SumBits'(amt_q);
    sat     = key_sum > SumBits'({imq_pkg::KeyBits{1'b1}});
    key_sat = sat ? {imq_pkg::KeyBits{1'b1}} : key_sum[imq_pkg::KeyBits-1:0];
  end

  // Down: best of cur, left, right; on equal keys the earlier arrival wins.
  always_comb begin
    a_beats      = a_ok_q && !lower(a_e_q, cur_e_q);
    best_e       = a_beats ? a_e_q : cur_e_q;
    best_idx     = a_beats ? left_idx : cur_q;
    b_beats_best = b_ok_q && !lower(b_e_q, best_e);
    if (b_beats_best) begin
      best_e   = b_e_q;
      best_idx = right_idx;
    end
    a_lower_cur = (cur_q != '0) && lower(a_e_q, cur_e_q);
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_q[AW-1:0];
    wr_data = cur_e_q;
    rd_en   = 1'b0;
    rd_addr = cur_q[AW-1:0];
    unique case (cmd_i.op)
      imq_pkg::OpInsert: begin
        wr_en   = 1'b1;
        wr_addr = count_q[AW-1:0];
        wr_data = '{id: id_q, key: key_sat, seq: seq_q};
      end
      imq_pkg::OpScanRd: begin
        rd_en   = 1'b1;
        rd_addr = scan_q[AW-1:0];
      end
      imq_pkg::OpRaiseWr: begin
        wr_en   = 1'b1;
        wr_data = '{id: rd_q.id, key: key_sat, seq: rd_q.seq};
      end
      imq_pkg::OpRemMove: begin
        wr_en   = (cur_q != count_q - CW'(1));
        wr_data = rd_q;
        rd_en   = 1'b0;
      end
      imq_pkg::OpRdCur: rd_en = 1'b1;
      imq_pkg::OpRdA: begin
        rd_en   = 1'b1;
        rd_addr = cmd_i.down ? left_idx[AW-1:0] : parent_idx[AW-1:0];
      end
      imq_pkg::OpRdB: begin
        rd_en   = 1'b1;
        rd_addr = right_idx[AW-1:0];
      end
      imq_pkg::OpSwapA: begin
        wr_en   = 1'b1;
        wr_data = cmd_i.down ? best_e : a_e_q;
      end
      imq_pkg::OpSwapB: begin
        wr_en   = 1'b1;
        wr_data = cur_e_q;
      end
      imq_pkg::OpRdTop: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      default: ;
    endcase
  end

  // Remove needs the last entry: it is fetched into rd_q by the scan-check cycle
  // when the match hits.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem_q[rd_addr];
    else if (cmd_i.op == imq_pkg::OpScanChk && rd_q.id == id_q &&
             act_q == imq_pkg::ActRemove)
      rd_q <= mem_q[AW'(count_q - CW'(1))];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      seq_q   <= imq_pkg::SeqBits'(1);
    end else begin
      if (cmd_i.op == imq_pkg::OpInsert) begin
        count_q <= count_q + CW'(1);
        seq_q   <= seq_q + imq_pkg::SeqBits'(1);
      end else if (cmd_i.op == imq_pkg::OpRemMove) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  // Swap A moves the partner into the old cur slot; swap B writes the old cur entry
  // at the new position.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      imq_pkg::OpLoad: begin
        act_q    <= action_i;
        id_q     <= entry_id_i;
        amt_q    <= amount_i;
        status_q <= (action_i == imq_pkg::ActInsert &&
                     count_q >= CW'(imq_pkg::Capacity)) ? imq_pkg::StFull : imq_pkg::StOk;
        scan_q   <= '0;
      end
      imq_pkg::OpInsert: begin
        cur_q <= count_q;
        if (sat) status_q <= imq_pkg::StSat;
      end
      imq_pkg::OpScanRd: begin
        if (scan_q >= count_q) status_q <= imq_pkg::StNotFound;
      end
      imq_pkg::OpScanChk: begin
        if (rd_q.id == id_q) begin
          cur_q <= scan_q;
        end else begin
          scan_q <= scan_q + CW'(1);
        end
      end
      imq_pkg::OpRaiseWr: if (sat) status_q <= imq_pkg::StSat;
      imq_pkg::OpRdCur: begin
        a_ok_q <= 1'b0;
        b_ok_q <= 1'b0;
      end
      imq_pkg::OpRdA: begin
        cur_e_q <= rd_q;
        a_ok_q  <= cmd_i.down ? (left_idx < count_q) : 1'b1;
      end
      imq_pkg::OpRdB: begin
        a_e_q  <= rd_q;
        b_ok_q <= right_idx < count_q;
      end
      imq_pkg::OpCapture: begin
        if (cmd_i.down) b_e_q <= rd_q;
        else a_e_q <= rd_q;
      end
      imq_pkg::OpSwapA: begin
        cur_q  <= cmd_i.down ? best_idx : parent_idx;
        a_ok_q <= 1'b0;
        b_ok_q <= 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat_o.action    = act_q;
    stat_o.full      = count_q >= CW'(imq_pkg::Capacity);
    stat_o.scan_done = scan_q >= count_q;
    stat_o.found     = rd_q.id == id_q;
    stat_o.last_slot = cur_q == count_q - CW'(1);
    stat_o.up_swap   = a_lower_cur;
    stat_o.dn_swap   = best_idx != cur_q;
  end

  assign top_id_o   = (count_q == '0) ? '0 : rd_q.id;
  assign is_empty_o = count_q == '0;
  assign status_o   = status_q;

endmodule

// File: sv/indexed_max_priority_queue.sv
// Indexed max priority queue: a binary max-heap of up to 256 {id, key, seq} entries in one
// single-port memory, with a controller and a datapath. Depends on imq_pkg and imq_if.
//
// One beat at a time: an action beat (insert, raise key, remove by id, query) is taken,
// worked through and answered with a single result beat holding the top id, the empty
// flag and a status, before the next action beat is taken. A query or a rejected insert
// reads the top slot and answers. An insert writes at the end and sifts up at most 8
// levels. Raise and remove first scan the heap slot by slot for the id, then sift: raise
// sifts up; remove moves the last entry into the hole, sifts it down and then sifts it up
// from where it stopped. Duplicate ids act on the lowest slot holding them. Keys saturate
// at all ones with status 3; a full heap rejects an insert with status 1; an unknown id
// gives status 2. The heap memory needs no clearing: only values from live slots are used.
module indexed_max_priority_queue (
  input  logic  clk_i,
  input  logic  rst_ni,
  imq_if.sink   in_i,
  imq_if.source out_o
);

  imq_pkg::cmd_t  cmd;
  imq_pkg::stat_t stat;
  logic [imq_pkg::IdBits-1:0] top_id;
  logic                       is_empty;
  logic [1:0]                 status;

  imq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  imq_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .action_i   (in_i.data.action),
    .entry_id_i (in_i.data.entry_id),
    .amount_i   (in_i.data.amount),
    .stat_o     (stat),
    .top_id_o   (top_id),
    .is_empty_o (is_empty),
    .status_o   (status)
  );

  // Hold the result beat steady while it waits.
  assign out_o.data.top_id   = top_id;
  assign out_o.data.is_empty = is_empty;
  assign out_o.data.status   = status;

endmodule

// File: bench/tb_indexed_max_priority_queue.sv
// Testbench for indexed_max_priority_queue: directed and random action beats checked
// against a behavioral heap predictor. Depends on imq_pkg, imq_if and the RTL top level.
module tb_indexed_max_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import imq_pkg::*;

  // Payload layouts of the two channels.
  typedef struct packed {
    logic [1:0]         action;
    logic [IdBits-1:0]  entry_id;
    logic [AmtBits-1:0] amount;
  } action_beat_t;

  typedef struct packed {
    logic [IdBits-1:0] top_id;
    logic              is_empty;
    logic [1:0]        status;
  } answer_beat_t;

  localparam int unsigned StallLimit = 5000;  // several times the worst beat latency
  localparam int unsigned DrainWait  = 700;   // one worst-case action after the last answer

  logic clk_i;
  logic rst_ni;

  imq_if #(.payload_t(action_beat_t)) act_if ();
  imq_if #(.payload_t(answer_beat_t)) ans_if ();

  indexed_max_priority_queue u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (act_if.sink),
    .out_o  (ans_if.source)
  );

  // Predicted heap contents and the answers still owed by the block.
  entry_t       heap_q [Capacity];
  int unsigned  heap_cnt;
  logic [31:0]  next_seq;
  answer_beat_t owed_answers [$];

  int unsigned  fail_cnt;
  int unsigned  idle_cycles;
  bit           sender_burst;   // no gaps on the action side while set
  bit           receiver_burst; // no stalls on the answer side while set

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Heap predictor
  // ---------------------------------------------------------------------------

  // True when a ranks strictly below b: smaller key, or equal key and later arrival.
  function automatic bit ranks_below(entry_t a, entry_t b);
    if (a.key != b.key) return a.key < b.key;
    return a.seq > b.seq;
  endfunction

  function automatic void swap_entries(int unsigned a, int unsigned b);
    entry_t t;
    t = heap_q[a];
    heap_q[a] = heap_q[b];
    heap_q[b] = t;
  endfunction

  function automatic void bubble_up(int unsigned i);
    int unsigned p;
    while (i > 0 && i < heap_cnt) begin
      p = (i - 1) / 2;
      if (!ranks_below(heap_q[p], heap_q[i])) break;
      swap_entries(p, i);
      i = p;
    end
  endfunction

  function automatic void bubble_down(int unsigned i);
    int unsigned best;
    int unsigned l;
    while (i < heap_cnt) begin
      best = i;
      l = 2 * i + 1;
      if (l < heap_cnt && !ranks_below(heap_q[l], heap_q[best])) best = l;
      if (l + 1 < heap_cnt && !ranks_below(heap_q[l + 1], heap_q[best])) best = l + 1;
      if (best == i) break;
      swap_entries(best, i);
      i = best;
    end
  endfunction

  // Lowest slot holding id, or -1.
  function automatic int locate_id(logic [IdBits-1:0] id);
    for (int i = 0; i < heap_cnt; i++)
      if (heap_q[i].id == id) return i;
    return -1;
  endfunction

  // Apply one action to the predicted heap and return the answer it should produce.
  function automatic answer_beat_t apply_action(action_beat_t b);
    answer_beat_t ans;
    int           pos;
    int unsigned  raised;
    ans.status = StOk;
    case (b.action)
      ActInsert: begin
        if (heap_cnt >= Capacity) begin
          ans.status = StFull;
        end else begin
          heap_q[heap_cnt].id  = b.entry_id;
          heap_q[heap_cnt].key = b.amount[KeyBits-1:0];
          heap_q[heap_cnt].seq = next_seq;
          next_seq = next_seq + 32'd1;
          heap_cnt++;
          bubble_up(heap_cnt - 1);
        end
      end
      ActRaise: begin
        pos = locate_id(b.entry_id);
        if (pos < 0) begin
          ans.status = StNotFound;
        end else begin
          raised = heap_q[pos].key + b.amount;
          if (raised > (1 << KeyBits) - 1) begin
            raised = (1 << KeyBits) - 1;
            ans.status = StSat;
          end
          heap_q[pos].key = raised[KeyBits-1:0];
          bubble_up(pos);
        end
      end
      ActRemove: begin
        pos = locate_id(b.entry_id);
        if (pos < 0) begin
          ans.status = StNotFound;
        end else begin
          heap_cnt--;
          if (pos != heap_cnt) begin
            heap_q[pos] = heap_q[heap_cnt];
            bubble_down(pos);
            bubble_up(pos);
          end
        end
      end
      default: ;
    endcase
    ans.is_empty = (heap_cnt == 0);
    ans.top_id   = (heap_cnt == 0) ? '0 : heap_q[0].id;
    return ans;
  endfunction

  // ---------------------------------------------------------------------------
  // Action side: one beat per call, random gap (none in a sender burst) before it
  // ---------------------------------------------------------------------------
  task automatic send_action(logic [1:0] act, logic [IdBits-1:0] id, logic [AmtBits-1:0] amt);
    action_beat_t b;
    int unsigned  gap;
    b.action   = act;
    b.entry_id = id;
    b.amount   = amt;
    gap = sender_burst ? 0 : $urandom_range(0, 15);
    // Drop valid only when a gap is wanted, so valid is never lowered and raised in one step.
    if (gap > 0) begin
      act_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    act_if.valid <= 1'b1;
    act_if.data  <= b;
    @(posedge clk_i);
    while (!(act_if.valid && act_if.ready)) @(posedge clk_i);
    owed_answers.insert(owed_answers.size(), apply_action(b));
  endtask

  // Answer side: stall a random number of cycles before every beat unless in a receiver burst.
  initial begin
    int unsigned stall;
    ans_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = receiver_burst ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        ans_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      ans_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!(ans_if.valid && ans_if.ready)) @(posedge clk_i);
    end
  end

  // Compare every accepted answer beat with the oldest prediction.
  always @(posedge clk_i) begin
    answer_beat_t want;
    answer_beat_t got;
    if (rst_ni && ans_if.valid && ans_if.ready) begin
      got = ans_if.data;
      if (owed_answers.size() == 0) begin
        $display("%0t: unexpected answer top_id=%0d is_empty=%0d status=%0d",
                 $time, got.top_id, got.is_empty, got.status);
        fail_cnt++;
      end else begin
        want = owed_answers.pop_front();
        if (got.top_id !== want.top_id) begin
          $display("%0t: top_id expected %0d got %0d", $time, want.top_id, got.top_id);
          fail_cnt++;
        end
        if (got.is_empty !== want.is_empty) begin
          $display("%0t: is_empty expected %0d got %0d", $time, want.is_empty, got.is_empty);
          fail_cnt++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a beat.
  always @(posedge clk_i) begin
    if ((act_if.valid && act_if.ready) || (ans_if.valid && ans_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("tb_indexed_max_priority_queue failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty heap, extremes of ids and keys, saturation, duplicates, misses, all actions.
  task automatic test_directed();
    send_action(ActQuery,  16'h0000, 8'h00);
    send_action(ActRemove, 16'h1234, 8'h00);   // miss on empty heap
    send_action(ActRaise,  16'hFFFF, 8'hFF);   // miss on empty heap
    send_action(ActInsert, 16'hFFFF, 8'h00);
    send_action(ActInsert, 16'h0000, 8'hFF);
    send_action(ActInsert, 16'h5555, 8'hFF);   // equal key, later arrival stays below
    send_action(ActInsert, 16'hAAAA, 8'h80);
    send_action(ActRaise,  16'hAAAA, 8'h7F);   // reaches the maximum exactly
    send_action(ActRaise,  16'hFFFF, 8'hFF);   // reaches the maximum exactly
    send_action(ActRaise,  16'h0000, 8'h01);   // already at the maximum: saturates
    send_action(ActInsert, 16'h0042, 8'h10);
    send_action(ActInsert, 16'h0042, 8'h20);   // duplicate id
    send_action(ActRaise,  16'h0042, 8'h00);   // zero increase
    send_action(ActRemove, 16'h0042, 8'hFF);   // lowest slot copy goes
    send_action(ActRemove, 16'h0000, 8'h00);   // remove a maximum-key entry that is not the top
    send_action(ActQuery,  16'hFFFF, 8'hFF);
    send_action(ActRemove, 16'h7777, 8'h00);   // miss on non-empty heap
    send_action(ActRemove, 16'h0042, 8'h00);
    send_action(ActRemove, 16'h5555, 8'h00);
    send_action(ActRemove, 16'hAAAA, 8'h00);
    send_action(ActRemove, 16'hFFFF, 8'h00);   // back to empty
    send_action(ActQuery,  16'h0001, 8'h01);
  endtask

  // Fill to capacity, reject one insert, raise and remove deep entries, then drain.
  task automatic test_full_heap();
    sender_burst = 1'b1;
    for (int i = 0; i < Capacity; i++)
      send_action(ActInsert, 16'(i), 8'($urandom_range(0, 255)));
    sender_burst = 1'b0;
    send_action(ActInsert, 16'hBEEF, 8'h01);   // heap full
    send_action(ActRaise,  16'(Capacity - 1), 8'($urandom_range(0, 255)));
    send_action(ActRemove, 16'(Capacity - 1), 8'h00);
    send_action(ActRaise,  16'hBEEF, 8'h01);   // miss after a full scan
    sender_burst = 1'b1;
    for (int i = 0; i < Capacity - 1; i++)
      send_action(ActRemove, 16'($urandom_range(0, Capacity - 2)), 8'h00);
    while (heap_cnt > 0) send_action(ActRemove, heap_q[heap_cnt - 1].id, 8'h00);
    sender_burst = 1'b0;
  endtask

  // Random mix; ids mostly from a small pool so raises and removes usually hit.
  task automatic test_random_mix(int unsigned n_items);
    logic [1:0]        act;
    logic [IdBits-1:0] id;
    int unsigned       roll;
    int unsigned       target;
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        sender_burst   = ($urandom_range(0, 3) == 0);
        receiver_burst = ($urandom_range(0, 3) == 0);
        target = $urandom_range(1, 40);
      end
      roll = $urandom_range(0, 99);
      if (roll < (heap_cnt < target ? 55 : 20)) act = ActInsert;
      else if (roll < 70) act = ActRaise;
      else if (roll < 92) act = ActRemove;
      else act = ActQuery;
      case ($urandom_range(0, 9))
        0:       id = 16'($urandom_range(0, 65535));
        1, 2, 3: id = (heap_cnt > 0) ? heap_q[$urandom_range(0, heap_cnt - 1)].id : 16'd0;
        default: id = 16'($urandom_range(0, 31));
      endcase
      send_action(act, id, 8'($urandom_range(0, 255)));
    end
    sender_burst   = 1'b0;
    receiver_burst = 1'b0;
  endtask

  initial begin
    int unsigned waited;
    act_if.valid   = 1'b0;
    act_if.data    = '0;
    rst_ni         = 1'b0;
    heap_cnt       = 0;
    next_seq       = 32'd1;
    fail_cnt       = 0;
    idle_cycles    = 0;
    sender_burst   = 1'b0;
    receiver_burst = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_heap();
    test_random_mix(320);

    // Hold valid low and drain the outstanding answers, then let the block settle.
    act_if.valid <= 1'b0;
    waited = 0;
    while (owed_answers.size() > 0 && waited < StallLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DrainWait) @(posedge clk_i);
    if (fail_cnt == 0 && owed_answers.size() == 0) begin
      $display("tb_indexed_max_priority_queue passed");
    end else begin
      $display("tb_indexed_max_priority_queue failed");
    end
    $finish;
  end

endmodule
